// File: rtl/arp_request_responder_unit_assert.svh
// assertion macros for the arp responder
`ifndef ARP_REQUEST_RESPONDER_UNIT_ASSERT_SVH
`define ARP_REQUEST_RESPONDER_UNIT_ASSERT_SVH

// checked outside reset
`define ARPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define ARPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/arpr_pkg.sv
package arpr_pkg;

  localparam int unsigned HDR_LEN = 42;
  localparam int unsigned HDR_AW  = $clog2(HDR_LEN);
  localparam int unsigned POS_W   = $clog2(HDR_LEN + 1);
  localparam int unsigned REQ_LEN = 10;

  localparam logic [POS_W-1:0] LAST_HDR_POS = POS_W'(HDR_LEN - 1);
  localparam logic [POS_W-1:0] POS_FULL     = POS_W'(HDR_LEN);
  localparam logic [POS_W-1:0] REQ_START    = POS_W'(12);
  localparam logic [POS_W-1:0] REQ_END      = POS_W'(21);
  localparam logic [POS_W-1:0] TIP_START    = POS_W'(38);

  localparam logic [7:0] ARP_OP_REPLY = 8'h02;

  localparam logic [7:0] ARP_REQ_HDR [REQ_LEN] = '{
    8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h01
  };

  localparam logic [47:0] OWN_MAC_RST = 48'h704D7B112233;
  localparam logic [31:0] OWN_IP_RST  = 32'hC0A8014D;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'b1;

  typedef enum logic [1:0] {
    SRC_STORE,
    SRC_MAC,
    SRC_IP,
    SRC_OPCODE
  } src_e;

  typedef struct packed {
    src_e              src;
    logic [HDR_AW-1:0] addr;
    logic [2:0]        idx;
    logic              eop;
  } ucode_t;

  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
    return 8'(mac >> (6'd40 - {i, 3'b000}));
  endfunction

  function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] i);
    return 8'(ip >> {~i, 3'b000});
  endfunction

  // reply program, one control word per output byte
  function automatic ucode_t ucode_rom(input logic [HDR_AW-1:0] k);
    ucode_t uc;
    uc      = '{src: SRC_STORE, addr: '0, idx: '0, eop: 1'b0};
    uc.eop  = (k == HDR_AW'(HDR_LEN - 1));
    if (k < HDR_AW'(6)) begin
      uc.addr = k + HDR_AW'(6);
    end else if (k < HDR_AW'(12)) begin
      uc.src = SRC_MAC;
      uc.idx = 3'(k - HDR_AW'(6));
    end else if (k < HDR_AW'(21)) begin
      uc.addr = k;
    end else if (k == HDR_AW'(21)) begin
      uc.src = SRC_OPCODE;
    end else if (k < HDR_AW'(28)) begin
      uc.src = SRC_MAC;
      uc.idx = 3'(k - HDR_AW'(22));
    end else if (k < HDR_AW'(32)) begin
      uc.src = SRC_IP;
      uc.idx = 3'(k - HDR_AW'(28));
    end else begin
      uc.addr = k - HDR_AW'(10);
    end
    return uc;
  endfunction

  // header check for the byte at one frame position
  function automatic logic byte_ok(input logic [POS_W-1:0] pos, input logic [7:0] b,
                                   input logic [31:0] ip);
    logic ok;
    ok = 1'b1;
    if (pos >= REQ_START && pos <= REQ_END) begin
      ok = (b == ARP_REQ_HDR[4'(pos - REQ_START)]);
    end else if (pos >= TIP_START && pos <= LAST_HDR_POS) begin
      ok = (b == ip_byte(ip, 2'(pos - TIP_START)));
    end
    return ok;
  endfunction

endpackage

// File: rtl/arpr_ram.sv
module arpr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 42,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/arp_request_responder_unit.sv
// reply: header bytes are taken one per cycle; after byte 41 is taken, each
//   reply byte passes a store read (ST_FETCH), then an output load (ST_EMIT),
//   for all 42 bytes, and no input byte is taken meanwhile; pass-through bytes
//   move one per cycle while the output is not stalled
// reset: own mac and ip return to their defaults, position 0, collecting header
`include "arp_request_responder_unit_assert.svh"

module arp_request_responder_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [arpr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [47:0]                    cfg_data_i,
  input  logic                           rx_valid_i,
  output logic                           rx_ready_o,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           rx_last_i,
  output logic                           tx_valid_o,
  input  logic                           tx_ready_i,
  output logic [7:0]                     tx_byte_o,
  output logic                           tx_last_o
);
  import arpr_pkg::*;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PASS,
    ST_DISCARD,
    ST_FETCH,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [HDR_AW-1:0] upc_q, upc_d;
  logic              match_q, match_d;
  logic              rlast_q, rlast_d;
  logic [47:0]       own_mac_q, own_mac_d;
  logic [31:0]       own_ip_q, own_ip_d;
  logic              tx_valid_q, tx_valid_d;
  logic [7:0]        tx_byte_q, tx_byte_d;
  logic              tx_last_q, tx_last_d;

  logic              rx_fire;
  logic              out_free;
  logic              ram_we;
  logic              ram_re;
  logic [7:0]        ram_rdata;
  logic              chk_ok;
  logic              match_now;
  ucode_t            uc;
  logic [7:0]        src_byte;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !tx_valid_q || tx_ready_i;
  assign rx_fire     = rx_valid_i && rx_ready_o;
  assign uc          = ucode_rom(upc_q);
  assign chk_ok      = byte_ok(pos_q, rx_byte_i, own_ip_q);
  assign match_now   = ((pos_q == '0) || match_q) && chk_ok;
  assign ram_we      = rx_fire && (state_q == ST_COLLECT) && (pos_q < POS_FULL);
  assign ram_re      = (state_q == ST_FETCH);

  always_comb begin
    case (state_q)
      ST_COLLECT, ST_DISCARD: rx_ready_o = 1'b1;
      ST_PASS:                rx_ready_o = out_free;
      default:                rx_ready_o = 1'b0;
    endcase
  end

  always_comb begin
    case (uc.src)
      SRC_STORE: src_byte = ram_rdata;
      SRC_MAC:   src_byte = mac_byte(own_mac_q, uc.idx);
      SRC_IP:    src_byte = ip_byte(own_ip_q, uc.idx[1:0]);
      default:   src_byte = ARP_OP_REPLY;
    endcase
  end

  arpr_ram #(
    .Width(8),
    .Depth(HDR_LEN)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q[HDR_AW-1:0]),
    .wdata_i(rx_byte_i),
    .re_i   (ram_re),
    .raddr_i(uc.addr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    upc_d      = upc_q;
    match_d    = match_q;
    rlast_d    = rlast_q;
    own_mac_d  = own_mac_q;
    own_ip_d   = own_ip_q;
    tx_valid_d = tx_valid_q && !tx_ready_i;
    tx_byte_d  = tx_byte_q;
    tx_last_d  = tx_last_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OWN_MAC: own_mac_d = cfg_data_i;
        CFG_OWN_IP:  own_ip_d  = cfg_data_i[31:0];
        default:     ;
      endcase
    end

    case (state_q)
      ST_COLLECT: begin
        if (rx_fire) begin
          match_d = match_now;
          if (pos_q >= LAST_HDR_POS) begin
            pos_d = POS_FULL;
            if (match_now) begin
              state_d = ST_FETCH;
              upc_d   = '0;
              rlast_d = rx_last_i;
            end else begin
              state_d = ST_DISCARD;
            end
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
          if (rx_last_i) begin
            pos_d = '0;
            if (!match_now || pos_q < LAST_HDR_POS) begin
              state_d = ST_COLLECT;
            end
          end
        end
      end
      ST_PASS: begin
        if (rx_fire) begin
          tx_valid_d = 1'b1;
          tx_byte_d  = rx_byte_i;
          tx_last_d  = rx_last_i;
          if (rx_last_i) begin
            state_d = ST_COLLECT;
            pos_d   = '0;
          end
        end
      end
      ST_DISCARD: begin
        if (rx_fire && rx_last_i) begin
          state_d = ST_COLLECT;
          pos_d   = '0;
        end
      end
      ST_FETCH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          tx_valid_d = 1'b1;
          tx_byte_d  = src_byte;
          tx_last_d  = uc.eop && rlast_q;
          if (uc.eop) begin
            state_d = rlast_q ? ST_COLLECT : ST_PASS;
          end else begin
            upc_d   = upc_q + HDR_AW'(1);
            state_d = ST_FETCH;
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
        pos_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_COLLECT;
      pos_q      <= '0;
      upc_q      <= '0;
      match_q    <= 1'b0;
      rlast_q    <= 1'b0;
      own_mac_q  <= OWN_MAC_RST;
      own_ip_q   <= OWN_IP_RST;
      tx_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      upc_q      <= upc_d;
      match_q    <= match_d;
      rlast_q    <= rlast_d;
      own_mac_q  <= own_mac_d;
      own_ip_q   <= own_ip_d;
      tx_valid_q <= tx_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_byte_q <= tx_byte_d;
    tx_last_q <= tx_last_d;
  end

  assign tx_valid_o = tx_valid_q;
  assign tx_byte_o  = tx_byte_q;
  assign tx_last_o  = tx_last_q;

  `ARPR_ASSERT_ALWAYS(a_pos_range, (pos_q <= POS_FULL), "frame position beyond header length")
  `ARPR_ASSERT_ALWAYS(a_upc_range, (upc_q <= HDR_AW'(HDR_LEN - 1)), "reply step out of range")
  `ARPR_ASSERT(a_no_rx_in_reply, (state_q == ST_FETCH || state_q == ST_EMIT) |-> !rx_ready_o, "input taken during reply")
  `ARPR_ASSERT(a_reply_start, (state_q == ST_FETCH && upc_q == '0) |-> ($past(state_q) == ST_COLLECT && $past(pos_q) == LAST_HDR_POS), "reply started off header end")
  `ARPR_ASSERT(a_fetch_to_emit, (state_q == ST_FETCH) |=> (state_q == ST_EMIT), "store read not followed by output step")

endmodule

// File: tb/tb_arp_request_responder_unit.sv
module tb_arp_request_responder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import arpr_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  typedef enum logic [1:0] {
    COLLECTING,
    PASSING,
    DISCARDING
  } frame_mode_e;

  typedef enum int {
    FR_MATCH,
    FR_BAD_HDR,
    FR_BAD_IP,
    FR_SHORT,
    FR_NOISE
  } frame_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_beat_t;

  class arp_reply_scoreboard;
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [7:0]  hdr [HDR_LEN];
    int unsigned pos;
    frame_mode_e mode;
    tx_beat_t    reply_q [$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_replies;

    function new();
      own_mac   = OWN_MAC_RST;
      own_ip    = OWN_IP_RST;
      pos       = 0;
      mode      = COLLECTING;
      n_errors  = 0;
      n_checked = 0;
      n_replies = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
      if (idx == CFG_OWN_MAC) begin
        own_mac = val;
      end else begin
        own_ip = val[31:0];
      end
    endfunction

    function bit is_request_for_us();
      for (int i = 0; i < REQ_LEN; i++) begin
        if (hdr[12 + i] != ARP_REQ_HDR[i]) return 1'b0;
      end
      for (int i = 0; i < 4; i++) begin
        if (hdr[38 + i] != own_ip[31 - 8*i -: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function logic [7:0] reply_byte(int unsigned k);
      if (k < 6) return hdr[k + 6];
      if (k < 12) return own_mac[47 - 8*(k - 6) -: 8];
      if (k < 21) return hdr[k];
      if (k == 21) return ARP_OP_REPLY;
      if (k < 28) return own_mac[47 - 8*(k - 22) -: 8];
      if (k < 32) return own_ip[31 - 8*(k - 28) -: 8];
      return hdr[k - 10];
    endfunction

    function void note_rx_byte(logic [7:0] b, logic last);
      tx_beat_t beat;
      if (mode == COLLECTING) begin
        if (pos < HDR_LEN) hdr[pos] = b;
        if (pos >= HDR_LEN - 1) begin
          pos = HDR_LEN;
          if (is_request_for_us()) begin
            for (int k = 0; k < HDR_LEN; k++) begin
              beat.data = reply_byte(k);
              beat.last = (k == HDR_LEN - 1) && last;
              reply_q.push_back(beat);
            end
            n_replies++;
            mode = PASSING;
          end else begin
            mode = DISCARDING;
          end
        end else begin
          pos++;
        end
      end else if (mode == PASSING) begin
        beat.data = b;
        beat.last = last;
        reply_q.push_back(beat);
      end
      if (last) begin
        pos  = 0;
        mode = COLLECTING;
      end
    endfunction

    function void check_tx_byte(logic [7:0] b, logic last);
      tx_beat_t want;
      if (reply_q.size() == 0) begin
        $error("unexpected tx transfer: tx_byte %02h tx_last %0b", b, last);
        n_errors++;
        return;
      end
      want = reply_q.pop_front();
      n_checked++;
      if (b !== want.data) begin
        $error("tx_byte: expected %02h, actual %02h", want.data, b);
        n_errors++;
      end
      if (last !== want.last) begin
        $error("tx_last: expected %0b, actual %0b", want.last, last);
        n_errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [47:0]          cfg_data_i;
  logic                 rx_valid_i;
  logic                 rx_ready_o;
  logic [7:0]           rx_byte_i;
  logic                 rx_last_i;
  logic                 tx_valid_o;
  logic                 tx_ready_i;
  logic [7:0]           tx_byte_o;
  logic                 tx_last_o;

  arp_reply_scoreboard sb;
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  bit          hold_on   = 1'b0;
  int unsigned bytes_sent = 0;

  arp_request_responder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .rx_last_i   (rx_last_i),
    .tx_valid_o  (tx_valid_o),
    .tx_ready_i  (tx_ready_i),
    .tx_byte_o   (tx_byte_o),
    .tx_last_o   (tx_last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tx_valid_o && tx_ready_i) sb.check_tx_byte(tx_byte_o, tx_last_o);
      if (rx_valid_i && rx_ready_o) sb.note_rx_byte(rx_byte_i, rx_last_i);
    end
  end

  // tx side: random stalls, plus one long hold-off when requested
  initial begin
    int unsigned held;
    tx_ready_i = 1'b0;
    held = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_on && held < HOLD_CYCLES) begin
        held++;
        tx_ready_i <= 1'b0;
      end else begin
        if (!hold_on) held = 0;
        tx_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      rx_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    rx_last_i  <= last;
    do @(posedge clk_i); while (!rx_ready_o);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_kind_e kind, input int unsigned len);
    logic [7:0]  fr [$];
    int unsigned j;
    for (int i = 0; i < len || i < HDR_LEN; i++) fr.push_back(8'($urandom));
    if (kind != FR_NOISE) begin
      for (int i = 0; i < REQ_LEN; i++) fr[12 + i] = ARP_REQ_HDR[i];
      for (int i = 0; i < 4; i++) fr[38 + i] = sb.own_ip[31 - 8*i -: 8];
    end
    if (kind == FR_BAD_HDR) begin
      j = $urandom_range(21, 12);
      fr[j] = fr[j] ^ (8'h01 << $urandom_range(7));
    end else if (kind == FR_BAD_IP) begin
      j = $urandom_range(41, 38);
      fr[j] = fr[j] ^ (8'h01 << $urandom_range(7));
    end
    for (int i = 0; i < len; i++) send_byte(fr[i], i == len - 1);
  endtask

  task automatic end_rx();
    @(negedge clk_i);
    rx_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned gap, input int unsigned stall,
                           input int unsigned n_bytes);
    int unsigned stop;
    int unsigned pick;
    int unsigned len;
    frame_kind_e kind;
    gap_pct   = gap;
    stall_pct = stall;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 55) kind = FR_MATCH;
      else if (pick < 65) kind = FR_BAD_HDR;
      else if (pick < 75) kind = FR_BAD_IP;
      else if (pick < 90) kind = FR_SHORT;
      else kind = FR_NOISE;
      if (kind == FR_SHORT) begin
        len = $urandom_range(HDR_LEN - 1, 1);
      end else if ($urandom_range(3) == 0) begin
        len = HDR_LEN;
      end else if ($urandom_range(7) == 0) begin
        len = HDR_LEN + $urandom_range(24, 6);
      end else begin
        len = HDR_LEN + $urandom_range(5, 1);
      end
      send_frame(kind, len);
    end
    end_rx();
    wait_drained();
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_OWN_MAC;
    cfg_data_i  = '0;
    rx_valid_i  = 1'b0;
    rx_byte_i   = '0;
    rx_last_i   = 1'b0;
    sb = new();
    hold_on     = 1'b1;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed frames with the reset addresses, receiver held off at first
    send_frame(FR_SHORT, 1);
    send_frame(FR_MATCH, HDR_LEN);
    send_frame(FR_BAD_HDR, HDR_LEN + 1);
    send_frame(FR_BAD_IP, HDR_LEN);
    send_frame(FR_SHORT, HDR_LEN - 1);
    send_frame(FR_MATCH, HDR_LEN + 3);
    end_rx();
    wait_drained();
    hold_on = 1'b0;

    write_reg(CFG_OWN_MAC, '1);
    write_reg(CFG_OWN_IP, {16'($urandom), 32'hFFFF_FFFF});
    run_phase(0, 0, 30);

    write_reg(CFG_OWN_MAC, '0);
    write_reg(CFG_OWN_IP, '0);
    run_phase(74, 0, 30);

    write_reg(CFG_OWN_MAC, {16'($urandom), 32'($urandom)});
    write_reg(CFG_OWN_IP, {16'($urandom), 32'($urandom)});
    run_phase(0, 74, 30);

    write_reg(CFG_OWN_IP, {16'h0000, 32'($urandom)});
    run_phase(21, 21, 30);

    $display("sent %0d rx bytes in frames of every kind, under five handshake mixes",
             bytes_sent);
    $display("checked %0d tx transfers across %0d reply frames, %0d errors",
             sb.n_checked, sb.n_replies, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/arpr_pkg.sv
rtl/arpr_ram.sv
rtl/arp_request_responder_unit.sv
tb/tb_arp_request_responder_unit.sv
